// ----- sv/lsrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the line segment rectangle clipper.
// Used by lsrc_front, lsrc_back and the core; has no dependencies.
package lsrc_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int MAG_W       = 2 * COORD_W;
    localparam int DEN_W       = COORD_W;
    localparam int QUO_W       = MAG_W + 1;
    localparam int CROSS_W     = QUO_W + 1;
    localparam int DIV_LAT     = MAG_W + 2;

    localparam logic signed [CFG_W-1:0] CLIP_LOW_X_RST  = 16'sd0;
    localparam logic signed [CFG_W-1:0] CLIP_LOW_Y_RST  = 16'sd0;
    localparam logic signed [CFG_W-1:0] CLIP_HIGH_X_RST = 16'sd1023;
    localparam logic signed [CFG_W-1:0] CLIP_HIGH_Y_RST = 16'sd767;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LOW_X  = 2'd0,
        CFG_LOW_Y  = 2'd1,
        CFG_HIGH_X = 2'd2,
        CFG_HIGH_Y = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_REJECT   = 2'd0,
        MODE_PASS     = 2'd1,
        MODE_ONE_OUT  = 2'd2,
        MODE_BOTH_OUT = 2'd3
    } mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] lx;
        logic signed [COORD_W-1:0] ly;
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
    } edges_t;

    typedef struct packed {
        mode_t                     mode;
        logic                      swapped;
        logic                      oxh;
        logic                      oyh;
        logic                      xo;
        logic                      yo;
        logic                      dx_nz;
        logic                      dy_nz;
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ye;
    } seg_ctx_t;

    typedef struct packed {
        seg_ctx_t                 ctx;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dlx;
        logic signed [DIFF_W-1:0] dhx;
        logic signed [DIFF_W-1:0] dly;
        logic signed [DIFF_W-1:0] dhy;
    } seg_cmd_t;

endpackage

// ----- sv/lsrc_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts segments, classifies them against the clip rectangle,
// orders the end points and forms the differences. Depends on lsrc_pkg.
module lsrc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [4*lsrc_pkg::COORD_W-1:0]  s_tdata,
    input  lsrc_pkg::edges_t                edges,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output lsrc_pkg::seg_cmd_t              cmd
);

    logic               valid_reg;
    logic               valid_next;
    lsrc_pkg::seg_cmd_t cmd_reg;
    lsrc_pkg::seg_cmd_t cmd_next;
    logic               load;

    assign s_tready  = !valid_reg || cmd_ready;
    assign load      = s_tvalid && s_tready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        logic signed [lsrc_pkg::COORD_W-1:0] ax, ay, bx, by;
        logic sxl, sxh, syl, syh, exl, exh, eyl, eyh;
        logic s_in, e_in, rej;
        ax = s_tdata[lsrc_pkg::COORD_W-1:0];
        ay = s_tdata[2*lsrc_pkg::COORD_W-1:lsrc_pkg::COORD_W];
        bx = s_tdata[3*lsrc_pkg::COORD_W-1:2*lsrc_pkg::COORD_W];
        by = s_tdata[4*lsrc_pkg::COORD_W-1:3*lsrc_pkg::COORD_W];
        sxl = ax < edges.lx;
        sxh = !sxl && (ax > edges.hx);
        exl = bx < edges.lx;
        exh = !exl && (bx > edges.hx);
        syl = ay < edges.ly;
        syh = !syl && (ay > edges.hy);
        eyl = by < edges.ly;
        eyh = !eyl && (by > edges.hy);
        s_in = !(sxl || sxh || syl || syh);
        e_in = !(exl || exh || eyl || eyh);
        rej  = (sxl && exl) || (sxh && exh) || (syl && eyl) || (syh && eyh);

        if (rej) begin
            cmd_next.ctx.mode = lsrc_pkg::MODE_REJECT;
        end else if (s_in && e_in) begin
            cmd_next.ctx.mode = lsrc_pkg::MODE_PASS;
        end else if (s_in || e_in) begin
            cmd_next.ctx.mode = lsrc_pkg::MODE_ONE_OUT;
        end else begin
            cmd_next.ctx.mode = lsrc_pkg::MODE_BOTH_OUT;
        end
        cmd_next.ctx.swapped = !rej && !s_in && e_in;
        cmd_next.ctx.oxh = sxh || exh;
        cmd_next.ctx.oyh = syh || eyh;
        cmd_next.ctx.xo  = sxl || sxh || exl || exh;
        cmd_next.ctx.yo  = syl || syh || eyl || eyh;
        if (cmd_next.ctx.swapped) begin
            cmd_next.ctx.xs = bx;
            cmd_next.ctx.ys = by;
            cmd_next.ctx.xe = ax;
            cmd_next.ctx.ye = ay;
        end else begin
            cmd_next.ctx.xs = ax;
            cmd_next.ctx.ys = ay;
            cmd_next.ctx.xe = bx;
            cmd_next.ctx.ye = by;
        end
        cmd_next.dx  = lsrc_pkg::DIFF_W'(cmd_next.ctx.xe) - lsrc_pkg::DIFF_W'(cmd_next.ctx.xs);
        cmd_next.dy  = lsrc_pkg::DIFF_W'(cmd_next.ctx.ye) - lsrc_pkg::DIFF_W'(cmd_next.ctx.ys);
        cmd_next.dlx = lsrc_pkg::DIFF_W'(edges.lx) - lsrc_pkg::DIFF_W'(cmd_next.ctx.xs);
        cmd_next.dhx = lsrc_pkg::DIFF_W'(edges.hx) - lsrc_pkg::DIFF_W'(cmd_next.ctx.xs);
        cmd_next.dly = lsrc_pkg::DIFF_W'(edges.ly) - lsrc_pkg::DIFF_W'(cmd_next.ctx.ys);
        cmd_next.dhy = lsrc_pkg::DIFF_W'(edges.hy) - lsrc_pkg::DIFF_W'(cmd_next.ctx.ys);
        cmd_next.ctx.dx_nz = cmd_next.dx != '0;
        cmd_next.ctx.dy_nz = cmd_next.dy != '0;
    end

    always_comb begin
        if (s_tready) begin
            valid_next = s_tvalid;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ----- sv/lsrc_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the arithmetic back end.
// Register storage, read data taken from the head entry; no dependencies.
module lsrc_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- sv/lsrc_div.sv -----
`timescale 1ns / 1ps
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Input, bit-step, output registers; advances while en is high. No dependencies.
module lsrc_div #(
    parameter int NW = 48,
    parameter int DW = 24
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [NW:0]   num,
    input  logic signed [DW:0]   den,
    output logic signed [NW:0]   quo
);

    logic [DW-1:0]      rem_reg [0:NW];
    logic [NW-1:0]      nq_reg  [0:NW];
    logic [DW-1:0]      den_reg [0:NW];
    logic               neg_reg [0:NW];
    logic signed [NW:0] quo_reg;
    logic [NW:0]        num_abs;
    logic [DW:0]        den_abs;
    logic [NW:0]        quo_mag;

    assign num_abs = num[NW] ? (~num + 1'b1) : num;
    assign den_abs = den[DW] ? (~den + 1'b1) : den;
    assign quo_mag = {1'b0, nq_reg[NW]};
    assign quo     = quo_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= num_abs[NW-1:0];
            den_reg[0] <= den_abs[DW-1:0];
            neg_reg[0] <= num[NW] ^ den[DW];
            quo_reg    <= neg_reg[NW] ? (~quo_mag + 1'b1) : quo_mag;
        end
    end

    for (genvar i = 0; i < NW; i++) begin : g_step
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        logic          qbit;

        assign trial = {rem_reg[i], nq_reg[i][NW-1]};
        assign diff  = {1'b0, trial} - {2'b00, den_reg[i]};
        assign qbit  = !diff[DW+1];

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= qbit ? diff[DW-1:0] : trial[DW-1:0];
                nq_reg[i+1]  <= {nq_reg[i][NW-2:0], qbit};
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

endmodule

// ----- sv/lsrc_back.sv -----
`timescale 1ns / 1ps
// Back end: edge intercepts by multiply and pipelined divide, range tests and
// selection of the clipped end points. Depends on lsrc_pkg and lsrc_div.
module lsrc_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  lsrc_pkg::seg_cmd_t              cmd,
    input  lsrc_pkg::edges_t                edges,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [4*lsrc_pkg::COORD_W-1:0]  m_tdata,
    output logic [0:0]                      m_tuser
);

    localparam int CW  = lsrc_pkg::COORD_W;
    localparam int XW  = lsrc_pkg::CROSS_W;
    localparam int LAT = lsrc_pkg::DIV_LAT;

    localparam logic [3:0] FOUND_LR = 4'd3;
    localparam logic [3:0] FOUND_LT = 4'd5;
    localparam logic [3:0] FOUND_RT = 4'd6;
    localparam logic [3:0] FOUND_LB = 4'd9;
    localparam logic [3:0] FOUND_RB = 4'd10;
    localparam logic [3:0] FOUND_TB = 4'd12;

    logic en;

    logic                                      s1_vld_reg;
    lsrc_pkg::seg_ctx_t                        s1_ctx_reg;
    logic signed [lsrc_pkg::DIFF_W-1:0]        s1_dx_reg, s1_dy_reg;
    logic signed [lsrc_pkg::PROD_W-1:0]        prod_reg [0:3];

    logic [LAT-1:0]                            dv_vld_reg;
    lsrc_pkg::seg_ctx_t                        dv_ctx_reg [0:LAT-1];
    logic signed [lsrc_pkg::QUO_W-1:0]         quo [0:3];

    logic                                      s3_vld_reg;
    lsrc_pkg::seg_ctx_t                        s3_ctx_reg;
    logic signed [XW-1:0]                      s3_cross_reg [0:3];

    logic                                      s4_vld_reg;
    lsrc_pkg::seg_ctx_t                        s4_ctx_reg;
    logic signed [XW-1:0]                      s4_cross_reg [0:3];
    logic [3:0]                                s4_fin_reg;
    logic                                      s4_fye_reg, s4_fxs_reg;

    logic                                      out_vld_reg;
    logic [4*CW-1:0]                           out_data_reg;
    logic                                      out_vis_reg;

    logic                                      vis_next;
    logic [4*CW-1:0]                           data_next;

    assign en        = !out_vld_reg || m_tready;
    assign cmd_ready = en;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_vis_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= cmd_valid;
            dv_vld_reg  <= {dv_vld_reg[LAT-2:0], s1_vld_reg};
            s3_vld_reg  <= dv_vld_reg[LAT-1];
            s4_vld_reg  <= s3_vld_reg;
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctx_reg  <= cmd.ctx;
            s1_dx_reg   <= cmd.dx;
            s1_dy_reg   <= cmd.dy;
            prod_reg[0] <= cmd.dy * cmd.dlx;
            prod_reg[1] <= cmd.dy * cmd.dhx;
            prod_reg[2] <= cmd.dx * cmd.dly;
            prod_reg[3] <= cmd.dx * cmd.dhy;
            dv_ctx_reg[0] <= s1_ctx_reg;
            for (int i = 1; i < LAT; i++) begin
                dv_ctx_reg[i] <= dv_ctx_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_div
        lsrc_div #(
            .NW (lsrc_pkg::MAG_W),
            .DW (lsrc_pkg::DEN_W)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (prod_reg[k][lsrc_pkg::QUO_W-1:0]),
            .den  ((k < 2) ? s1_dx_reg : s1_dy_reg),
            .quo  (quo[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_ctx_reg      <= dv_ctx_reg[LAT-1];
            s3_cross_reg[0] <= XW'(dv_ctx_reg[LAT-1].ys) + XW'(quo[0]);
            s3_cross_reg[1] <= XW'(dv_ctx_reg[LAT-1].ys) + XW'(quo[1]);
            s3_cross_reg[2] <= XW'(dv_ctx_reg[LAT-1].xs) + XW'(quo[2]);
            s3_cross_reg[3] <= XW'(dv_ctx_reg[LAT-1].xs) + XW'(quo[3]);

            s4_ctx_reg    <= s3_ctx_reg;
            s4_cross_reg  <= s3_cross_reg;
            s4_fin_reg[0] <= s3_cross_reg[0] >= XW'(edges.ly) && s3_cross_reg[0] <= XW'(edges.hy);
            s4_fin_reg[1] <= s3_cross_reg[1] >= XW'(edges.ly) && s3_cross_reg[1] <= XW'(edges.hy);
            s4_fin_reg[2] <= s3_cross_reg[2] >= XW'(edges.lx) && s3_cross_reg[2] <= XW'(edges.hx);
            s4_fin_reg[3] <= s3_cross_reg[3] >= XW'(edges.lx) && s3_cross_reg[3] <= XW'(edges.hx);
            s4_fye_reg    <= s3_ctx_reg.ye >= edges.ly && s3_ctx_reg.ye <= edges.hy;
            s4_fxs_reg    <= s3_ctx_reg.xs >= edges.lx && s3_ctx_reg.xs <= edges.hx;

            out_vis_reg  <= vis_next;
            out_data_reg <= data_next;
        end
    end

    always_comb begin
        lsrc_pkg::seg_ctx_t c;
        logic signed [XW-1:0] x_edge, y_edge, y_cx, x_cy, ny_t, nx, ny;
        logic signed [XW-1:0] px [0:3];
        logic signed [XW-1:0] py [0:3];
        logic f_cx, in_r, f1, f2, f4, f8, ok;
        logic [3:0] found;
        logic [1:0] a, b;
        c = s4_ctx_reg;
        x_edge = c.oxh ? XW'(edges.hx) : XW'(edges.lx);
        y_edge = c.oyh ? XW'(edges.hy) : XW'(edges.ly);
        y_cx   = c.oxh ? s4_cross_reg[1] : s4_cross_reg[0];
        f_cx   = c.oxh ? s4_fin_reg[1] : s4_fin_reg[0];
        x_cy   = c.oyh ? s4_cross_reg[3] : s4_cross_reg[2];
        ny_t   = c.dx_nz ? y_cx : XW'(c.ye);
        in_r   = c.dx_nz ? f_cx : s4_fye_reg;
        nx     = x_edge;
        ny     = ny_t;
        if (c.yo && !c.xo) begin
            ny = y_edge;
            nx = (c.dx_nz && c.dy_nz) ? x_cy : XW'(c.xe);
        end else if (c.xo && c.yo && !in_r) begin
            ny = y_edge;
            nx = c.dy_nz ? x_cy : x_edge;
        end

        f1 = c.dx_nz && s4_fin_reg[0];
        f2 = c.dx_nz && s4_fin_reg[1];
        ok = !(c.dx_nz && !c.dy_nz) && !(f1 && f2);
        f4 = ok && (c.dx_nz ? s4_fin_reg[2] : s4_fxs_reg);
        f8 = ok && (c.dx_nz ? s4_fin_reg[3] : s4_fxs_reg);
        found = {f8, f4, f2, f1};
        px[0] = XW'(edges.lx);
        py[0] = s4_cross_reg[0];
        px[1] = XW'(edges.hx);
        py[1] = s4_cross_reg[1];
        px[2] = c.dx_nz ? s4_cross_reg[2] : XW'(c.xs);
        py[2] = XW'(edges.ly);
        px[3] = c.dx_nz ? s4_cross_reg[3] : XW'(c.xs);
        py[3] = XW'(edges.hy);
        a = 2'd0;
        b = 2'd1;

        vis_next  = 1'b0;
        data_next = '0;
        case (c.mode)
            lsrc_pkg::MODE_PASS: begin
                vis_next  = 1'b1;
                data_next = {c.ye, c.xe, c.ys, c.xs};
            end
            lsrc_pkg::MODE_ONE_OUT: begin
                vis_next = 1'b1;
                if (c.swapped) begin
                    data_next = {c.ys, c.xs, ny[CW-1:0], nx[CW-1:0]};
                end else begin
                    data_next = {ny[CW-1:0], nx[CW-1:0], c.ys, c.xs};
                end
            end
            lsrc_pkg::MODE_BOTH_OUT: begin
                vis_next = 1'b1;
                case (found)
                    FOUND_LR: begin a = 2'd0; b = 2'd1; end
                    FOUND_LT: begin a = 2'd0; b = 2'd2; end
                    FOUND_RT: begin a = 2'd1; b = 2'd2; end
                    FOUND_LB: begin a = 2'd0; b = 2'd3; end
                    FOUND_RB: begin a = 2'd1; b = 2'd3; end
                    FOUND_TB: begin a = 2'd2; b = 2'd3; end
                    default: begin
                        vis_next = 1'b0;
                    end
                endcase
                if (vis_next) begin
                    data_next = {py[b][CW-1:0], px[b][CW-1:0], py[a][CW-1:0], px[a][CW-1:0]};
                end
            end
            default: begin
                vis_next  = 1'b0;
                data_next = '0;
            end
        endcase
    end

endmodule

// ----- sv/line_segment_rect_clipper_core.sv -----
`timescale 1ns / 1ps
// Line segment clipper against an inclusive rectangle. Depends on lsrc_pkg,
// lsrc_front, lsrc_fifo, lsrc_back and lsrc_div.
// Segments pass through the front-end register, the command queue and the
// back end, where the pipelined intercept dividers (one quotient bit per
// stage) make up most of the pipeline. Throughput: one segment per cycle while the output is not stalled.
// Reset (aresetn, synchronous, active low) empties the pipeline and queue and
// loads the clip edges with 0, 0, 1023 and 767.
module line_segment_rect_clipper_core #(
    parameter int QUEUE_DEPTH = lsrc_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [4*lsrc_pkg::COORD_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    output logic [4*lsrc_pkg::COORD_W-1:0]      m_tdata,
    // visible
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [lsrc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lsrc_pkg::CFG_W-1:0]          cfg_wdata
);

    logic signed [lsrc_pkg::CFG_W-1:0] low_x_reg, low_y_reg, high_x_reg, high_y_reg;
    lsrc_pkg::edges_t   edges;
    logic               cmd_valid, cmd_ready, q_valid, q_ready;
    lsrc_pkg::seg_cmd_t cmd, q_cmd;
    logic [$bits(lsrc_pkg::seg_cmd_t)-1:0] q_data;

    function automatic logic signed [lsrc_pkg::COORD_W-1:0] scale_edge(
        input logic signed [lsrc_pkg::CFG_W-1:0] v
    );
        logic signed [31:0] w;
        w = 32'(v) <<< lsrc_pkg::FRAC_BITS;
        if (w > 32'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (w < -32'sd8388608) begin
            return 24'sh800000;
        end
        return w[lsrc_pkg::COORD_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_x_reg  <= lsrc_pkg::CLIP_LOW_X_RST;
            low_y_reg  <= lsrc_pkg::CLIP_LOW_Y_RST;
            high_x_reg <= lsrc_pkg::CLIP_HIGH_X_RST;
            high_y_reg <= lsrc_pkg::CLIP_HIGH_Y_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                lsrc_pkg::CFG_LOW_X:  low_x_reg  <= cfg_wdata;
                lsrc_pkg::CFG_LOW_Y:  low_y_reg  <= cfg_wdata;
                lsrc_pkg::CFG_HIGH_X: high_x_reg <= cfg_wdata;
                lsrc_pkg::CFG_HIGH_Y: high_y_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign edges.lx = scale_edge(low_x_reg);
    assign edges.ly = scale_edge(low_y_reg);
    assign edges.hx = scale_edge(high_x_reg);
    assign edges.hy = scale_edge(high_y_reg);
    assign q_cmd    = q_data;

    lsrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .edges     (edges),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    lsrc_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(lsrc_pkg::seg_cmd_t))
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd_valid),
        .in_ready  (cmd_ready),
        .in_data   (cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    lsrc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .edges     (edges),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
